/* hdl/ktm_pkg.sv */
// Shared types, keyword tables and status codes for the keyword trie matcher.
`timescale 1ns / 1ps
package ktm_pkg;

   localparam int NUM_WORDS = 21;
   localparam int MAX_LEN   = 12;
   localparam int DEPTH_W   = 4;
   localparam int CODE_W    = 5;

   localparam logic [1:0] STATUS_PREFIX = 2'd0;
   localparam logic [1:0] STATUS_DONE   = 2'd1;
   localparam logic [1:0] STATUS_DEAD   = 2'd2;

   // Words are right-aligned: the last character sits in the low byte.
   localparam logic [MAX_LEN*8-1:0] KW_CHARS [NUM_WORDS] = '{
      96'("do"), 96'("try"), 96'("case"), 96'("goto"), 96'("long"),
      96'("catch"), 96'("const"), 96'("float"), 96'("super"), 96'("throw"),
      96'("double"), 96'("switch"), 96'("throws"), 96'("default"),
      96'("finally"), 96'("private"), 96'("continue"), 96'("volatile"),
      96'("strictfp"), 96'("transient"), 96'("synchronized")
   };

   localparam logic [DEPTH_W-1:0] KW_LEN [NUM_WORDS] = '{
      4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
      4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd9, 4'd12
   };

   // Classified item: letter code 1..26 for 'a'..'z', 0 for any other byte.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              restart;
   } q_item_type;

endpackage

/* hdl/ktm_front.sv */
// Front end: classify incoming bytes into letter codes and queue them.
`timescale 1ns / 1ps
module ktm_front
   import ktm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_restart,
   output logic       q_valid,
   input  logic       q_ready,
   output q_item_type q_item
);

   q_item_type       slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             push, pop, is_lower;
   q_item_type       cls;

   assign is_lower    = (req_ch >= 8'h61) && (req_ch <= 8'h7A);
   assign cls.code    = is_lower ? req_ch[CODE_W-1:0] : '0;
   assign cls.restart = req_restart;

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= cls;
   end

endmodule

/* hdl/ktm_back.sv */
// Back end: advance the trie state and hold the result for the consumer.
`timescale 1ns / 1ps
module ktm_back
   import ktm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_ready,
   input  q_item_type q_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_keyword_id
);

   // Trie node is tracked as the set of words sharing the prefix plus its depth.
   logic [NUM_WORDS-1:0] alive_ff, alive_in, cur_alive;
   logic [DEPTH_W-1:0]   depth_ff, cur_depth;
   logic                 valid_ff;
   logic [1:0]           status_ff, status_in;
   logic [4:0]           id_ff, id_in;
   logic                 take;

   assign q_ready = !valid_ff || rsp_ready;
   assign take    = q_valid && q_ready;

   assign cur_alive = q_item.restart ? '1 : alive_ff;
   assign cur_depth = q_item.restart ? '0 : depth_ff;

   always_comb begin
      logic [7:0] c;
      alive_in = '0;
      id_in    = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         c = KW_CHARS[w][(KW_LEN[w] - cur_depth - 4'd1) * 8 +: 8];
         if (cur_alive[w] && (cur_depth < KW_LEN[w]) && (c[CODE_W-1:0] == q_item.code)
             && (q_item.code != '0)) begin
            alive_in[w] = 1'b1;
            if (KW_LEN[w] == cur_depth + 4'd1) id_in = id_in | 5'(w + 1);
         end
      end
      if (alive_in == '0) status_in = STATUS_DEAD;
      else if (id_in != '0) status_in = STATUS_DONE;
      else status_in = STATUS_PREFIX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         alive_ff <= '1;
         depth_ff <= '0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            alive_ff <= alive_in;
            depth_ff <= cur_depth + 4'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
         id_ff     <= id_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_keyword_id = id_ff;

endmodule

/* hdl/keyword_trie_matcher.sv */
// Top level of the keyword trie matcher: classifier queue feeding the trie stepper.
//
//   channel  ports                                    direction
//   req      req_valid/ready, req_ch, req_restart     in
//   rsp      rsp_valid/ready, rsp_status, rsp_keyword_id  out
//
// One item per cycle sustained while the receiver does not stall results.
// The queued item is stepped against all 21 words in the back end and registered.
// Synchronous reset empties the two-entry queue and returns to the start node.
// A stalled result holds; the queue keeps accepting until it has two items.
`timescale 1ns / 1ps
module keyword_trie_matcher
   import ktm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_keyword_id
);

   logic       q_valid, q_ready;
   q_item_type q_item;

   ktm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_ch, .req_restart,
      .q_valid, .q_ready, .q_item
   );

   ktm_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_keyword_id
   );

endmodule

/* test/ktm_checker.sv */
// Checker for the keyword trie matcher: predicts each result and compares it.
`timescale 1ns / 1ps
module ktm_checker
   import ktm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_restart,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_status,
   input  logic [4:0] rsp_keyword_id,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] keyword_id;
   } match_type;

   string word_set [NUM_WORDS] = '{
      "do", "try", "case", "goto", "long", "catch", "const", "float",
      "super", "throw", "double", "switch", "throws", "default", "finally",
      "private", "continue", "volatile", "strictfp", "transient",
      "synchronized"
   };

   // prefix tracking: the bytes seen since restart, or dead
   string     typed;
   bit        is_dead;
   match_type match_q[$];

   function automatic match_type next_match();
      match_type m;
      bit        any_prefix;
      m = '{STATUS_DEAD, 5'd0};
      any_prefix = 0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (typed.len() <= word_set[w].len() &&
             word_set[w].substr(0, typed.len() - 1) == typed) begin
            any_prefix = 1;
            if (word_set[w] == typed) m = '{STATUS_DONE, 5'(w + 1)};
         end
      end
      if (any_prefix && m.status != STATUS_DONE) m = '{STATUS_PREFIX, 5'd0};
      return m;
   endfunction

   always @(posedge clock) begin
      match_type exp_m;
      if (reset) begin
         typed = "";
         is_dead = 0;
         match_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_restart) begin
               typed = "";
               is_dead = 0;
            end
            // zero byte never lies on a word edge; keep string append safe
            if (is_dead || req_ch == 8'd0) begin
               is_dead = 1;
               exp_m = '{STATUS_DEAD, 5'd0};
            end else begin
               typed = {typed, string'(req_ch)};
               exp_m = next_match();
               if (exp_m.status == STATUS_DEAD) is_dead = 1;
            end
            match_q.push_back(exp_m);
         end
         if (rsp_valid && rsp_ready) begin
            if (match_q.size() == 0) begin
               $error("unexpected result status=%0d id=%0d", rsp_status, rsp_keyword_id);
               fail_count <= fail_count + 1;
            end else begin
               exp_m = match_q.pop_front();
               if (exp_m.status !== rsp_status) begin
                  $error("status expected %0d actual %0d", exp_m.status, rsp_status);
                  fail_count <= fail_count + 1;
               end else if (exp_m.keyword_id !== rsp_keyword_id) begin
                  $error("keyword_id expected %0d actual %0d",
                         exp_m.keyword_id, rsp_keyword_id);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending = match_q.size();
   end

endmodule

/* test/tb.sv */
// Testbench top for the keyword trie matcher: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
   import ktm_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_ch;
   logic       req_restart;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic [4:0] rsp_keyword_id;
   int         fail_count;
   int         pending;
   int         send_idle;
   int         recv_idle;
   int         hold_off;
   logic       hold_req;
   int         cycle_count;

   string words [NUM_WORDS] = '{
      "do", "try", "case", "goto", "long", "catch", "const", "float",
      "super", "throw", "double", "switch", "throws", "default", "finally",
      "private", "continue", "volatile", "strictfp", "transient",
      "synchronized"
   };

   keyword_trie_matcher dut (.*);
   ktm_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_off <= 0;
      end else if (hold_req) begin
         rsp_ready <= 0;
         hold_off <= 60;
      end else if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_byte(input logic [7:0] c, input logic rs);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_ch <= c;
      req_restart <= rs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_word(input string s, input int extra);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
      for (int i = 0; i < extra; i++) send_byte(8'($urandom_range(255)), 0);
   endtask

   task automatic random_items(input int n);
      int k;
      string s;
      k = 0;
      while (k < n) begin
         case ($urandom_range(9))
            0, 1: begin
               send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
               k++;
            end
            2: begin
               // word prefix followed by a random byte and a random letter
               s = words[$urandom_range(NUM_WORDS - 1)];
               s = s.substr(0, $urandom_range(s.len() - 1));
               send_word(s, 1);
               send_byte(8'($urandom_range(97, 122)), 0);
               k += s.len() + 2;
            end
            default: begin
               s = words[$urandom_range(NUM_WORDS - 1)];
               send_word(s, $urandom_range(2));
               k += s.len() + 1;
            end
         endcase
      end
      req_valid <= 0;
      @(posedge clock);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_ch = 0;
      req_restart = 0;
      send_idle = 0;
      recv_idle = 0;
      hold_req = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, dead persistence, restart while dead, word extension
      send_byte(8'h00, 1);
      send_byte(8'hff, 0);
      send_byte(8'h64, 1);
      send_byte(8'h6f, 0);
      send_byte(8'h75, 0);
      send_byte(8'h62, 0);
      send_byte(8'h6c, 0);
      send_byte(8'h65, 0);
      send_byte(8'h78, 0);
      send_byte(8'h74, 1);
      send_word("throws", 1);
      send_word("synchronized", 0);
      req_valid <= 0;
      hold_req <= 1;
      @(posedge clock);
      hold_req <= 0;
      send_word("do", 0);
      send_word("case", 0);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      send_idle = 7; recv_idle = 73;
      random_items(450);
      while (pending != 0) @(posedge clock);
      send_idle = 73; recv_idle = 7;
      random_items(450);
      send_idle = 0; recv_idle = 0;
      random_items(450);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
